[src/assert_macros.svh]
// Assertion helpers shared by the resolver modules.
// Both expect a clock named clock and a reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SACR_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define SACR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/sacr_pkg.sv]
package sacr_pkg;

   // operation codes of a request
   localparam logic [1:0] OP_PACKET    = 2'd0;
   localparam logic [1:0] OP_SLOT      = 2'd1;
   localparam logic [1:0] OP_CYCLE_END = 2'd2;

   // register indexes (byte address bits [3:2])
   localparam logic [1:0] REG_START_ADDRESS = 2'd0;
   localparam logic [1:0] REG_CALL_COMMAND  = 2'd1;
   localparam logic [1:0] REG_CYCLE_COUNT   = 2'd2;
   localparam logic [1:0] REG_RECEIVE_CYCLE = 2'd3;

   localparam int CSR_ADDR_W = 4;

   // register reset values
   localparam logic [7:0] START_ADDRESS_RESET = 8'd1;
   localparam logic [7:0] CALL_COMMAND_RESET  = 8'hCA;
   localparam logic [7:0] CYCLE_COUNT_RESET   = 8'd8;
   localparam logic [7:0] RECEIVE_CYCLE_RESET = 8'd0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;    // latch the accepted request, restart the scan
      logic scan;    // step the neighbor list scan
      logic commit;  // update state and load the result register
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
   } ctrl_status_type;

endpackage

[src/sacr_req_if.sv]
interface sacr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] packet_command;
   logic [7:0] sender_address;

   modport source (output valid, output operation, output packet_command,
                   output sender_address, input ready);
   modport sink (input valid, input operation, input packet_command,
                 input sender_address, output ready);
endinterface

[src/sacr_rsp_if.sv]
interface sacr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  own_address;
   logic [15:0] slot_time;
   logic        align_request;
   logic [7:0]  align_address;
   logic        transmit_call;
   logic        radio_listen;
   logic        neighbor_seen;
   logic [7:0]  cycle_index;

   modport source (output valid, output own_address, output slot_time,
                   output align_request, output align_address, output transmit_call,
                   output radio_listen, output neighbor_seen, output cycle_index,
                   input ready);
   modport sink (input valid, input own_address, input slot_time,
                 input align_request, input align_address, input transmit_call,
                 input radio_listen, input neighbor_seen, input cycle_index,
                 output ready);
endinterface

[src/slot_address_collision_resolver_core.sv]
// Channel   Dir  Handshake          Payload
// req_chan  in   valid/ready        operation, packet_command, sender_address
// rsp_chan  out  valid/ready        own_address .. cycle_index (one per request)
// csr_*     in   APB, pready high   four 8-bit registers at byte 0, 4, 8, 12
//
// A request is accepted, then the neighbor list is scanned with one memory read
// per stored entry, the last entry read is compared, the scan is seen done, and
// the result is committed.
// Reset is synchronous and active high; registers return to reset values,
// the neighbor list memory is not cleared (the fill count guards it).
// The result register decouples the channels: a new request is taken while a
// result still waits, and commit waits only if that result is still held.
module slot_address_collision_resolver_core #(
   parameter int SEEN_DEPTH = 32,
   parameter int SLOT_SHIFT = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   sacr_req_if.sink                        req_chan,
   sacr_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sacr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   sacr_pkg::ctrl_cmd_type    cmd;
   sacr_pkg::ctrl_status_type status;

   // writes complete in the access cycle
   assign csr_pready = 1'b1;

   // sequence accept, scan and commit
   sacr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // hold registers, neighbor list and result payload
   sacr_dp #(
      .SEEN_DEPTH (SEEN_DEPTH),
      .SLOT_SHIFT (SLOT_SHIFT)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_operation      (req_chan.operation),
      .req_packet_command (req_chan.packet_command),
      .req_sender_address (req_chan.sender_address),
      .rsp_own_address    (rsp_chan.own_address),
      .rsp_slot_time      (rsp_chan.slot_time),
      .rsp_align_request  (rsp_chan.align_request),
      .rsp_align_address  (rsp_chan.align_address),
      .rsp_transmit_call  (rsp_chan.transmit_call),
      .rsp_radio_listen   (rsp_chan.radio_listen),
      .rsp_neighbor_seen  (rsp_chan.neighbor_seen),
      .rsp_cycle_index    (rsp_chan.cycle_index),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata)
   );

endmodule

[src/sacr_ctrl.sv]
`include "assert_macros.svh"

module sacr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  sacr_pkg::ctrl_status_type status,
   output sacr_pkg::ctrl_cmd_type    cmd
);

   sacr_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sacr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         sacr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sacr_pkg::ST_SCAN;
            end
         end
         sacr_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) state_in = sacr_pkg::ST_FINISH;
         end
         sacr_pkg::ST_FINISH: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = sacr_pkg::ST_IDLE;
            end
         end
         default: state_in = sacr_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `SACR_ASSERT(a_commit_slot_free, !cmd.commit || !rsp_valid_ff || rsp_ready, "commit over pending result")
   `SACR_ASSERT_NEXT(a_accept_starts_scan, req_valid && req_ready, state_ff == sacr_pkg::ST_SCAN, "accept did not start scan")
   `SACR_ASSERT_NEXT(a_commit_shows_result, cmd.commit, rsp_valid_ff && state_ff == sacr_pkg::ST_IDLE, "commit lost result")

endmodule

[src/sacr_dp.sv]
`include "assert_macros.svh"

module sacr_dp #(
   parameter int SEEN_DEPTH = 32,
   parameter int SLOT_SHIFT = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sacr_pkg::ctrl_cmd_type              cmd,
   output sacr_pkg::ctrl_status_type           status,
   input  logic [1:0]                          req_operation,
   input  logic [7:0]                          req_packet_command,
   input  logic [7:0]                          req_sender_address,
   output logic [7:0]                          rsp_own_address,
   output logic [15:0]                         rsp_slot_time,
   output logic                                rsp_align_request,
   output logic [7:0]                          rsp_align_address,
   output logic                                rsp_transmit_call,
   output logic                                rsp_radio_listen,
   output logic                                rsp_neighbor_seen,
   output logic [7:0]                          rsp_cycle_index,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sacr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata
);

   localparam int CNT_W = $clog2(SEEN_DEPTH + 1);
   localparam int IDX_W = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(SEEN_DEPTH);

   // configuration
   logic [7:0] start_address_ff, call_command_ff, cycle_count_ff, receive_cycle_ff;
   logic       csr_wr;
   logic [1:0] csr_idx;

   // block state
   logic [7:0]       slot_ff, slot_in;
   logic             tx_en_ff, tx_en_in;
   logic [7:0]       cycle_ff, cycle_in;
   logic [CNT_W-1:0] seen_count_ff, seen_count_in;
   logic             listen_ff, listen_in;
   logic             indicator_ff, indicator_in;

   // latched request
   logic [1:0] op_ff;
   logic [7:0] command_ff, sender_ff;

   // scan
   logic [CNT_W-1:0] scan_idx_ff;
   logic             rd_pend_ff, hit_ff, rd_en;
   logic [7:0]       rd_data_ff;
   logic [7:0]       seen_mem [SEEN_DEPTH];

   // commit
   logic       wr_en;
   logic       align;
   logic [7:0] align_addr;
   logic       send;
   logic [7:0] cycle_inc;

   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_address_ff <= sacr_pkg::START_ADDRESS_RESET;
         call_command_ff  <= sacr_pkg::CALL_COMMAND_RESET;
         cycle_count_ff   <= sacr_pkg::CYCLE_COUNT_RESET;
         receive_cycle_ff <= sacr_pkg::RECEIVE_CYCLE_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            sacr_pkg::REG_START_ADDRESS: start_address_ff <= csr_pwdata[7:0];
            sacr_pkg::REG_CALL_COMMAND:  call_command_ff  <= csr_pwdata[7:0];
            sacr_pkg::REG_CYCLE_COUNT:   cycle_count_ff   <= csr_pwdata[7:0];
            sacr_pkg::REG_RECEIVE_CYCLE: receive_cycle_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         sacr_pkg::REG_START_ADDRESS: csr_prdata = {24'd0, start_address_ff};
         sacr_pkg::REG_CALL_COMMAND:  csr_prdata = {24'd0, call_command_ff};
         sacr_pkg::REG_CYCLE_COUNT:   csr_prdata = {24'd0, cycle_count_ff};
         sacr_pkg::REG_RECEIVE_CYCLE: csr_prdata = {24'd0, receive_cycle_ff};
         default:                     csr_prdata = 32'd0;
      endcase
   end

   // latch the request (the scan is restarted below)
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_operation;
         command_ff <= req_packet_command;
         sender_ff  <= req_sender_address;
      end
   end

   assign rd_en = cmd.scan && (scan_idx_ff < seen_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         rd_pend_ff  <= 1'b0;
         hit_ff      <= 1'b0;
      end else if (cmd.load) begin
         scan_idx_ff <= '0;
         rd_pend_ff  <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         rd_pend_ff <= rd_en;
         if (rd_en) scan_idx_ff <= scan_idx_ff + 1'b1;
         if (rd_pend_ff && rd_data_ff == sender_ff) hit_ff <= 1'b1;
      end
   end

   assign status.scan_done = (scan_idx_ff == seen_count_ff) && !rd_pend_ff;

   always_ff @(posedge clock) begin
      if (wr_en) seen_mem[seen_count_ff[IDX_W-1:0]] <= sender_ff;
      if (rd_en) rd_data_ff <= seen_mem[scan_idx_ff[IDX_W-1:0]];
   end

   always_comb begin
      slot_in       = slot_ff;
      tx_en_in      = tx_en_ff;
      cycle_in      = cycle_ff;
      seen_count_in = seen_count_ff;
      listen_in     = listen_ff;
      indicator_in  = indicator_ff;
      align         = 1'b0;
      align_addr    = 8'd0;
      send          = 1'b0;
      wr_en         = 1'b0;
      cycle_inc     = cycle_ff + 8'd1;
      case (op_ff)
         sacr_pkg::OP_PACKET: begin
            if (command_ff == call_command_ff) begin
               if (sender_ff == slot_ff) begin
                  // collision: move to the next address
                  align      = 1'b1;
                  align_addr = sender_ff;
                  tx_en_in   = 1'b0;
                  slot_in    = slot_ff + 8'd1;
               end else begin
                  if (sender_ff < slot_ff) begin
                     align      = 1'b1;
                     align_addr = sender_ff;
                  end
                  if (!hit_ff && seen_count_ff < DEPTH_C) begin
                     wr_en         = cmd.commit;
                     seen_count_in = seen_count_ff + 1'b1;
                  end
               end
            end
         end
         sacr_pkg::OP_SLOT: begin
            if (tx_en_ff) begin
               send      = 1'b1;
               listen_in = 1'b1;
            end
         end
         sacr_pkg::OP_CYCLE_END: begin
            cycle_in      = (cycle_inc == cycle_count_ff) ? 8'd0 : cycle_inc;
            tx_en_in      = 1'b1;
            listen_in     = (cycle_in == receive_cycle_ff);
            indicator_in  = (seen_count_ff != '0);
            seen_count_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff       <= sacr_pkg::START_ADDRESS_RESET;
         tx_en_ff      <= 1'b0;
         cycle_ff      <= 8'd0;
         seen_count_ff <= '0;
         listen_ff     <= 1'b0;
         indicator_ff  <= 1'b0;
      end else if (csr_wr && csr_idx == sacr_pkg::REG_START_ADDRESS) begin
         slot_ff <= csr_pwdata[7:0];
      end else if (cmd.commit) begin
         slot_ff       <= slot_in;
         tx_en_ff      <= tx_en_in;
         cycle_ff      <= cycle_in;
         seen_count_ff <= seen_count_in;
         listen_ff     <= listen_in;
         indicator_ff  <= indicator_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_own_address   <= slot_in;
         rsp_slot_time     <= 16'(slot_in) << SLOT_SHIFT;
         rsp_align_request <= align;
         rsp_align_address <= align_addr;
         rsp_transmit_call <= send;
         rsp_radio_listen  <= listen_in;
         rsp_neighbor_seen <= indicator_in;
         rsp_cycle_index   <= cycle_in;
      end
   end

   `SACR_ASSERT(a_count_in_range, seen_count_ff <= DEPTH_C, "seen count beyond depth")
   `SACR_ASSERT(a_scan_in_range, !cmd.scan || scan_idx_ff <= seen_count_ff, "scan past list")
   `SACR_ASSERT(a_no_write_while_scan, !(wr_en && cmd.scan), "list written during scan")

endmodule
